FILE: hdl/wat_pkg.sv
// Shared types and constants for the waypoint arrival tracker.
`default_nettype none
package wat_pkg;
	localparam int CW = 24;
	localparam logic [22:0] RADIUS_ONE = 23'd256;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_POS   = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	localparam logic [2:0] ST_MOVING   = 3'd0;
	localparam logic [2:0] ST_ADVANCED = 3'd1;
	localparam logic [2:0] ST_DONE     = 3'd2;
	localparam logic [2:0] ST_IDLE     = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_VERT   = 1'b1;

	typedef struct packed {
		logic [1:0]           mode;
		logic signed [CW-1:0] coord_x;
		logic signed [CW-1:0] coord_y;
		logic signed [CW-1:0] coord_z;
		logic [63:0]          target_id;
		logic [2:0]           action_kind;
		logic [22:0]          arrive_radius;
		logic                 path_first;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [2:0]           active_kind;
		logic [63:0]          active_target;
		logic [3:0]           waypoint_index;
		logic signed [CW-1:0] goal_x;
		logic signed [CW-1:0] goal_y;
		logic signed [CW-1:0] goal_z;
		logic [31:0]          generation;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_diff;  // latch differences
		logic mul_step;   // one multiply step
		logic finish;     // apply result
	} dp_cmd_t;

	typedef struct packed {
		logic need_test;  // sample needs the arrival test
		logic mul_last;
	} dp_sts_t;
endpackage
`default_nettype wire

FILE: hdl/waypoint_arrival_tracker_top.sv
// Top level of the waypoint arrival tracker.
// Usage: pulse start with an input transaction while busy is low; busy rises
// next cycle. Config writes (cfg_we/cfg_index/cfg_data) only while idle.
// Start/load/stop transactions and ignored samples pass from accept through
// the difference and finish states to the result strobe; position samples
// while active also pass through the multiply state, where one shared 27x27
// multiplier steps through twenty-one products (squares, dot product, squared
// radius, and the two final wide products of four partial products each).
// Throughput: one transaction at a time, next accepted once busy falls.
// Results appear on res for one cycle with done high; the receiver cannot
// stall. Reset clears action, path length, radius to 1.0 and generation;
// the path store itself is not cleared.
`default_nettype none
module waypoint_arrival_tracker_top #(
	parameter int MAX_WAYPOINTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire wat_pkg::in_item_t  req,
	output logic                    done,
	output wat_pkg::out_item_t      res,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic               cfg_data
);
	import wat_pkg::*;
	logic en_q, vert_q, acc;
	dp_cmd_t cmd;
	dp_sts_t sts;
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1; vert_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLE) en_q <= cfg_data;
			if (cfg_index == CFG_VERT) vert_q <= cfg_data;
		end
	end

	wat_ctrl u_ctrl (.clk, .arst_n, .start(acc), .sts, .cmd, .busy);
	wat_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp (
		.clk, .arst_n, .capture(acc), .in_item(req), .enable(en_q),
		.use_vertical(vert_q), .cmd, .sts, .res, .res_valid(done));
endmodule
`default_nettype wire

FILE: hdl/wat_ctrl.sv
// Controller sequencing one transaction through the datapath.
`default_nettype none
module wat_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire wat_pkg::dp_sts_t sts,
	output wat_pkg::dp_cmd_t      cmd,
	output logic                  busy
);
	import wat_pkg::*;
	typedef enum logic [1:0] {S_IDLE, S_DIFF, S_MUL, S_FIN} st_t;
	st_t st_q;

	always_comb begin
		cmd = '0;
		cmd.load_diff = (st_q == S_DIFF);
		cmd.mul_step  = (st_q == S_MUL);
		cmd.finish    = (st_q == S_FIN);
	end
	assign busy = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: if (start) st_q <= S_DIFF;
				S_DIFF: st_q <= sts.need_test ? S_MUL : S_FIN;
				S_MUL: if (sts.mul_last) st_q <= S_FIN;
				S_FIN: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hdl/wat_dp.sv
// Datapath: state registers, path store, arrival arithmetic.
`default_nettype none
module wat_dp #(
	parameter int MAX_WAYPOINTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              capture,
	input  wire wat_pkg::in_item_t in_item,
	input  wire logic              enable,
	input  wire logic              use_vertical,
	input  wire wat_pkg::dp_cmd_t  cmd,
	output wat_pkg::dp_sts_t       sts,
	output wat_pkg::out_item_t     res,
	output logic                   res_valid
);
	import wat_pkg::*;
	localparam int PW = $clog2(MAX_WAYPOINTS);
	localparam int LW = $clog2(MAX_WAYPOINTS + 1);
	localparam int DW = CW + 1;     // difference width
	localparam int SW = 2 * DW + 2; // sum of three squares
	localparam int BW = 2 * SW + 1; // final products
	localparam int HW = SW / 2;     // half of a wide operand
	localparam int MW = HW + 1;     // signed multiplier operand width

	in_item_t item_q;
	logic [2:0] act_q;
	logic [63:0] tgt_q;
	logic signed [CW-1:0] dest_q [3];
	logic signed [CW-1:0] prev_q [3];
	logic prev_valid_q;
	logic [22:0] rad_q;
	logic [LW-1:0] len_q;
	logic [PW-1:0] pos_q;
	logic [31:0] gen_q;
	logic [3*CW-1:0] mem [MAX_WAYPOINTS];
	logic [3*CW-1:0] rd_q;

	// differences e=dest-p, d=p-prev, w=dest-prev
	logic signed [DW-1:0] e_q [3], d_q [3], w_q [3];
	logic [4:0] step_q;
	logic [SW-1:0] sq_q, len2_q, ww_q, r2_q;
	logic signed [SW:0] dot_q;
	logic [BW-1:0] lhs_q, rhs_q;

	// shared multiplier operands per step
	logic signed [MW-1:0] ma, mb;
	logic signed [2*MW-1:0] prod;
	logic [2*HW-1:0] pu;
	logic [SW-1:0] xr, dot_u;
	logic nz;
	assign nz = use_vertical;
	assign xr = ww_q - r2_q;
	assign dot_u = dot_q[SW-1:0];

	// wide products are built from four half-width partial products each
	always_comb begin
		ma = '0; mb = '0;
		case (step_q)
			5'd0: begin ma = MW'(e_q[0]); mb = MW'(e_q[0]); end
			5'd1: begin ma = MW'(e_q[1]); mb = MW'(e_q[1]); end
			5'd2: begin ma = MW'(e_q[2]); mb = MW'(e_q[2]); end
			5'd3: begin ma = MW'(d_q[0]); mb = MW'(d_q[0]); end
			5'd4: begin ma = MW'(d_q[1]); mb = MW'(d_q[1]); end
			5'd5: begin ma = MW'(d_q[2]); mb = MW'(d_q[2]); end
			5'd6: begin ma = MW'(w_q[0]); mb = MW'(w_q[0]); end
			5'd7: begin ma = MW'(w_q[1]); mb = MW'(w_q[1]); end
			5'd8: begin ma = MW'(w_q[2]); mb = MW'(w_q[2]); end
			5'd9: begin ma = MW'(w_q[0]); mb = MW'(d_q[0]); end
			5'd10: begin ma = MW'(w_q[1]); mb = MW'(d_q[1]); end
			5'd11: begin ma = MW'(w_q[2]); mb = MW'(d_q[2]); end
			5'd12: begin ma = MW'($signed({1'b0, rad_q})); mb = ma; end
			5'd13: begin
				ma = $signed({1'b0, xr[HW-1:0]}); mb = $signed({1'b0, len2_q[HW-1:0]});
			end
			5'd14: begin
				ma = $signed({1'b0, xr[HW-1:0]}); mb = $signed({1'b0, len2_q[SW-1:HW]});
			end
			5'd15: begin
				ma = $signed({1'b0, xr[SW-1:HW]}); mb = $signed({1'b0, len2_q[HW-1:0]});
			end
			5'd16: begin
				ma = $signed({1'b0, xr[SW-1:HW]}); mb = $signed({1'b0, len2_q[SW-1:HW]});
			end
			5'd17: begin
				ma = $signed({1'b0, dot_u[HW-1:0]}); mb = $signed({1'b0, dot_u[HW-1:0]});
			end
			5'd18: begin
				ma = $signed({1'b0, dot_u[HW-1:0]}); mb = $signed({1'b0, dot_u[SW-1:HW]});
			end
			5'd19: begin
				ma = $signed({1'b0, dot_u[SW-1:HW]}); mb = $signed({1'b0, dot_u[HW-1:0]});
			end
			5'd20: begin
				ma = $signed({1'b0, dot_u[SW-1:HW]}); mb = $signed({1'b0, dot_u[SW-1:HW]});
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod = ma * mb;
	assign pu = prod[2*HW-1:0];
	logic use_term;
	assign use_term = !((step_q == 5'd2 || step_q == 5'd5 || step_q == 5'd8 ||
		step_q == 5'd11) && !nz);

	assign sts.mul_last = (step_q == 5'd20);
	assign sts.need_test = (item_q.mode == MODE_POS) && enable && (act_q != 3'd0);

	// decision from accumulated terms
	logic hit_pt, hit;
	always_comb begin
		hit_pt = (sq_q <= r2_q);
		if (hit_pt) hit = 1'b1;
		else if (!prev_valid_q || len2_q == '0) hit = 1'b0;
		else if (dot_q <= 0) hit = (ww_q <= r2_q);
		else if (dot_q >= $signed({1'b0, len2_q})) hit = 1'b0;
		else if (ww_q <= r2_q) hit = 1'b1;
		else hit = (lhs_q <= rhs_q);
	end

	logic [LW-1:0] nxt;
	assign nxt = LW'(pos_q) + LW'(1);

	always_ff @(posedge clk) begin
		if (capture) item_q <= in_item;
		rd_q <= mem[nxt[PW-1:0]];
		if (cmd.load_diff) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [CW-1:0] pc;
				pc = (i == 0) ? item_q.coord_x : (i == 1) ? item_q.coord_y : item_q.coord_z;
				e_q[i] <= DW'(dest_q[i]) - DW'(pc);
				d_q[i] <= DW'(pc) - DW'(prev_q[i]);
				w_q[i] <= DW'(dest_q[i]) - DW'(prev_q[i]);
			end
			sq_q <= '0; len2_q <= '0; ww_q <= '0; dot_q <= '0;
		end
		if (cmd.mul_step && use_term) begin
			if (step_q <= 5'd2) sq_q <= sq_q + SW'(prod);
			else if (step_q <= 5'd5) len2_q <= len2_q + SW'(prod);
			else if (step_q <= 5'd8) ww_q <= ww_q + SW'(prod);
			else if (step_q <= 5'd11) dot_q <= dot_q + (SW+1)'(prod);
			else if (step_q == 5'd12) r2_q <= SW'(prod);
			else if (step_q == 5'd13) lhs_q <= BW'(pu);
			else if (step_q <= 5'd15) lhs_q <= lhs_q + (BW'(pu) << HW);
			else if (step_q == 5'd16) lhs_q <= lhs_q + (BW'(pu) << (2 * HW));
			else if (step_q == 5'd17) rhs_q <= BW'(pu);
			else if (step_q <= 5'd19) rhs_q <= rhs_q + (BW'(pu) << HW);
			else rhs_q <= rhs_q + (BW'(pu) << (2 * HW));
		end
		if (cmd.finish && item_q.mode == MODE_LOAD) begin
			if (item_q.path_first || len_q == '0)
				mem[0] <= {item_q.coord_x, item_q.coord_y, item_q.coord_z};
			else if (len_q < LW'(MAX_WAYPOINTS))
				mem[len_q[PW-1:0]] <= {item_q.coord_x, item_q.coord_y, item_q.coord_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			act_q <= '0; tgt_q <= '0; rad_q <= RADIUS_ONE;
			len_q <= '0; pos_q <= '0; gen_q <= '0; prev_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin dest_q[i] <= '0; prev_q[i] <= '0; end
			res_valid <= 1'b0; res <= '0;
		end else begin
			res_valid <= 1'b0;
			if (cmd.load_diff) step_q <= '0;
			else if (cmd.mul_step) step_q <= step_q + 5'd1;
			if (cmd.finish) begin
				res_valid <= 1'b1;
				res.status <= ST_IDLE;
				res.active_kind <= act_q;
				res.active_target <= tgt_q;
				res.waypoint_index <= 4'(pos_q);
				res.goal_x <= dest_q[0]; res.goal_y <= dest_q[1]; res.goal_z <= dest_q[2];
				res.generation <= gen_q;
				case (mode_t'(item_q.mode))
					MODE_START: begin
						if (enable && item_q.action_kind != 3'd0 && item_q.action_kind != 3'd7) begin
							gen_q <= gen_q + 32'd1;
							act_q <= item_q.action_kind; tgt_q <= item_q.target_id;
							dest_q[0] <= item_q.coord_x; dest_q[1] <= item_q.coord_y;
							dest_q[2] <= item_q.coord_z;
							rad_q <= item_q.arrive_radius;
							len_q <= '0; pos_q <= '0; prev_valid_q <= 1'b0;
							res.status <= ST_MOVING;
							res.active_kind <= item_q.action_kind;
							res.active_target <= item_q.target_id;
							res.waypoint_index <= '0;
							res.goal_x <= item_q.coord_x; res.goal_y <= item_q.coord_y;
							res.goal_z <= item_q.coord_z;
							res.generation <= gen_q + 32'd1;
						end
					end
					MODE_LOAD: begin
						if (item_q.path_first || len_q == '0) begin
							len_q <= LW'(1); pos_q <= '0; prev_valid_q <= 1'b0;
							dest_q[0] <= item_q.coord_x; dest_q[1] <= item_q.coord_y;
							dest_q[2] <= item_q.coord_z;
							res.waypoint_index <= '0;
							res.goal_x <= item_q.coord_x; res.goal_y <= item_q.coord_y;
							res.goal_z <= item_q.coord_z;
							res.status <= (act_q != 3'd0) ? ST_MOVING : ST_IDLE;
						end else if (len_q >= LW'(MAX_WAYPOINTS)) begin
							res.status <= ST_FULL;
						end else begin
							len_q <= len_q + LW'(1);
							res.status <= (act_q != 3'd0) ? ST_MOVING : ST_IDLE;
						end
					end
					MODE_STOP: begin
						act_q <= '0; tgt_q <= '0; len_q <= '0; pos_q <= '0;
						rad_q <= RADIUS_ONE; prev_valid_q <= 1'b0;
						res.active_kind <= '0; res.active_target <= '0;
						res.waypoint_index <= '0;
					end
					MODE_POS: begin
						if (sts.need_test) begin
							if (hit && !(len_q != '0 && nxt < len_q)) begin
								res.status <= ST_DONE;
								act_q <= '0; tgt_q <= '0; len_q <= '0; pos_q <= '0;
								rad_q <= RADIUS_ONE; prev_valid_q <= 1'b0;
								res.waypoint_index <= '0;
							end else begin
								res.status <= ST_MOVING;
								prev_valid_q <= 1'b1;
								prev_q[0] <= item_q.coord_x; prev_q[1] <= item_q.coord_y;
								prev_q[2] <= item_q.coord_z;
								if (hit) begin
									res.status <= ST_ADVANCED;
									pos_q <= nxt[PW-1:0];
									res.waypoint_index <= 4'(nxt);
									dest_q[0] <= rd_q[3*CW-1:2*CW];
									dest_q[1] <= rd_q[2*CW-1:CW];
									dest_q[2] <= rd_q[CW-1:0];
									res.goal_x <= rd_q[3*CW-1:2*CW];
									res.goal_y <= rd_q[2*CW-1:CW];
									res.goal_z <= rd_q[CW-1:0];
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/wat_checker.sv
// Port-level checks for the waypoint arrival tracker.
`default_nettype none
module wat_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy fell without result");
endmodule
bind waypoint_arrival_tracker_top wat_checker u_chk (.clk, .arst_n, .start, .busy, .done);
`default_nettype wire

FILE: bench/arrival_checker.sv
// Checker for the waypoint arrival tracker: tracks configuration, predicts and compares results.
`default_nettype none
module arrival_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire wat_pkg::in_item_t  req,
	input  wire logic               done,
	input  wire wat_pkg::out_item_t res,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic               cfg_data,
	output int                      errors,
	output int                      pending
);
	import wat_pkg::*;

	localparam int PATH_DEPTH = 16;

	typedef logic signed [CW-1:0] coord_t;

	logic         en_q, vert_q;
	logic [2:0]   act_kind;
	logic [63:0]  act_target;
	coord_t       goal [3];
	logic [22:0]  radius;
	coord_t       path [PATH_DEPTH][3];
	logic [4:0]   path_len;
	logic [3:0]   path_pos;
	coord_t       last_pos [3];
	logic         last_ok;
	logic [31:0]  gen_count;

	out_item_t    expected_results [$];

	function automatic void drop_action();
		act_kind   = '0;
		act_target = '0;
		path_len   = '0;
		path_pos   = '0;
		radius     = RADIUS_ONE;
		last_ok    = 1'b0;
	endfunction

	// exact squared-distance arrival test, point then swept segment
	function automatic logic arrived(input coord_t p [3]);
		int n;
		longint e, d [3], w [3], sq, seg_len, ww, dot, r2;
		logic signed [127:0] lhs, rhs;
		n  = vert_q ? 3 : 2;
		r2 = longint'(radius) * longint'(radius);
		sq = 0;
		for (int i = 0; i < n; i++) begin
			e = longint'(goal[i]) - longint'(p[i]);
			sq += e * e;
		end
		if (sq <= r2)
			return 1'b1;
		if (!last_ok)
			return 1'b0;
		seg_len = 0;
		ww = 0;
		dot = 0;
		for (int i = 0; i < n; i++) begin
			d[i] = longint'(p[i]) - longint'(last_pos[i]);
			w[i] = longint'(goal[i]) - longint'(last_pos[i]);
			seg_len += d[i] * d[i];
			ww += w[i] * w[i];
			dot += w[i] * d[i];
		end
		if (seg_len == 0)
			return 1'b0;
		if (dot <= 0)
			return ww <= r2;
		if (dot >= seg_len)
			return 1'b0;
		if (ww <= r2)
			return 1'b1;
		lhs = 128'(ww - r2) * 128'(seg_len);
		rhs = 128'(dot) * 128'(dot);
		return lhs <= rhs;
	endfunction

	function automatic out_item_t make_result(input logic [2:0] st, input logic [2:0] kind,
			input logic [63:0] tgt);
		out_item_t r;
		r.status         = st;
		r.active_kind    = kind;
		r.active_target  = tgt;
		r.waypoint_index = path_pos;
		r.goal_x         = goal[0];
		r.goal_y         = goal[1];
		r.goal_z         = goal[2];
		r.generation     = gen_count;
		return r;
	endfunction

	function automatic out_item_t predict_result(input in_item_t it);
		coord_t p [3];
		logic [2:0] kind;
		logic [63:0] tgt;
		p[0] = it.coord_x;
		p[1] = it.coord_y;
		p[2] = it.coord_z;
		case (mode_t'(it.mode))
			MODE_START: begin
				if (!en_q || it.action_kind == 3'd0 || it.action_kind == 3'd7)
					return make_result(ST_IDLE, act_kind, act_target);
				gen_count++;
				act_kind   = it.action_kind;
				act_target = it.target_id;
				goal       = p;
				radius     = it.arrive_radius;
				path_len   = '0;
				path_pos   = '0;
				last_ok    = 1'b0;
				return make_result(ST_MOVING, act_kind, act_target);
			end
			MODE_LOAD: begin
				if (it.path_first || path_len == 0) begin
					path[0]  = p;
					path_len = 5'd1;
					path_pos = '0;
					last_ok  = 1'b0;
					goal     = p;
				end else if (path_len >= PATH_DEPTH) begin
					return make_result(ST_FULL, act_kind, act_target);
				end else begin
					path[path_len[3:0]] = p;
					path_len++;
				end
				return make_result(act_kind != 0 ? ST_MOVING : ST_IDLE, act_kind, act_target);
			end
			MODE_STOP: begin
				drop_action();
				return make_result(ST_IDLE, act_kind, act_target);
			end
			default: begin
				if (!en_q || act_kind == 0)
					return make_result(ST_IDLE, act_kind, act_target);
				if (arrived(p)) begin
					if (path_len > 0 && 5'(path_pos) + 5'd1 < path_len) begin
						path_pos++;
						goal = path[path_pos];
						last_pos = p;
						last_ok  = 1'b1;
						return make_result(ST_ADVANCED, act_kind, act_target);
					end
					kind = act_kind;
					tgt  = act_target;
					drop_action();
					return make_result(ST_DONE, kind, tgt);
				end
				last_pos = p;
				last_ok  = 1'b1;
				return make_result(ST_MOVING, act_kind, act_target);
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			en_q       = 1'b1;
			vert_q     = 1'b0;
			gen_count  = '0;
			goal       = '{default: '0};
			last_pos   = '{default: '0};
			act_kind   = '0;
			act_target = '0;
			path_len   = '0;
			path_pos   = '0;
			radius     = RADIUS_ONE;
			last_ok    = 1'b0;
			errors     = 0;
			pending   <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ENABLE)
					en_q = cfg_data;
				else
					vert_q = cfg_data;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transaction %h", $time, res);
					errors++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", 64'(e.status), 64'(res.status));
					check_field("active_kind", 64'(e.active_kind), 64'(res.active_kind));
					check_field("active_target", e.active_target, res.active_target);
					check_field("waypoint_index", 64'(e.waypoint_index),
						64'(res.waypoint_index));
					check_field("goal_x", 64'(e.goal_x), 64'(res.goal_x));
					check_field("goal_y", 64'(e.goal_y), 64'(res.goal_y));
					check_field("goal_z", 64'(e.goal_z), 64'(res.goal_z));
					check_field("generation", 64'(e.generation), 64'(res.generation));
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_result(req));
			pending <= expected_results.size();
		end
	end
endmodule
`default_nettype wire

FILE: bench/tb_waypoint_arrival_tracker_top.sv
// Testbench top for the waypoint arrival tracker: stimulus, configuration phases and verdict.
`default_nettype none
module tb_waypoint_arrival_tracker_top;
	import wat_pkg::*;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_MOVE = 3'd1;
	localparam logic [2:0] KIND_FACE = 3'd6;
	localparam logic [2:0] KIND_BAD  = 3'd7;
	localparam logic signed [CW-1:0] C_MIN = 24'sh800000;
	localparam logic signed [CW-1:0] C_MAX = 24'sh7fffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	in_item_t req = '0;
	out_item_t res;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic cfg_data = 1'b0;
	int errors, pending;
	int sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	waypoint_arrival_tracker_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	arrival_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	function automatic in_item_t mk(input mode_t m, input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
			input logic [63:0] tgt, input logic [2:0] kind, input logic [22:0] rad,
			input logic first);
		in_item_t it;
		it.mode = m;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		it.target_id = tgt;
		it.action_kind = kind;
		it.arrive_radius = rad;
		it.path_first = first;
		return it;
	endfunction

	function automatic logic signed [CW-1:0] jitter(input int span);
		return CW'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic in_item_t noise();
		logic [191:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return in_item_t'(r[$bits(in_item_t)-1:0]);
	endfunction

	task automatic send(input in_item_t it);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
		repeat (gap) @(posedge clk);
		@(posedge clk);
		start <= 1'b1;
		req   <= it;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		sent++;
	endtask

	// hold off until every result is in and the block has drained
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic val);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// start an action, maybe load a path, then walk samples through each waypoint
	task automatic run_route();
		logic signed [CW-1:0] pts [$];
		logic signed [CW-1:0] ox, oy, oz, bx, by, bz;
		int nwp, span, rad;
		bit sweep;
		rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8388607) : $urandom_range(0, 3000);
		bx = jitter(1 << 20);
		by = jitter(1 << 20);
		bz = jitter(1 << 20);
		send(mk(MODE_START, bx, by, bz, {$urandom, $urandom}, 3'($urandom_range(1, 6)),
			23'(rad), 1'($urandom_range(0, 1))));
		nwp = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 4);
		pts.delete();
		if (nwp == 0) begin
			pts.push_back(bx); pts.push_back(by); pts.push_back(bz);
		end
		for (int i = 0; i < nwp; i++) begin
			bx = jitter(1 << 20);
			by = jitter(1 << 20);
			bz = jitter(1 << 20);
			send(mk(MODE_LOAD, bx, by, bz, {$urandom, $urandom}, 3'($urandom),
				23'($urandom), (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0)));
			if (i < 16) begin
				pts.push_back(bx); pts.push_back(by); pts.push_back(bz);
			end
		end
		for (int k = 0; k + 2 < pts.size(); k += 3) begin
			span = (rad > 4000 ? 4000 : rad) * 4 + 16;
			repeat ($urandom_range(1, 3)) begin
				sweep = 1'($urandom_range(0, 1));
				ox = jitter(span);
				oy = jitter(span);
				oz = ($urandom_range(0, 3) == 0) ? jitter(1 << 16) : jitter(span);
				if ($urandom_range(0, 15) == 0)
					send(noise());
				send(mk(MODE_POS, pts[k] + ox, pts[k+1] + oy, pts[k+2] + oz, {$urandom, $urandom},
					3'($urandom), 23'($urandom), 1'($urandom_range(0, 1))));
				if (sweep)
					send(mk(MODE_POS, pts[k] - ox + jitter(8), pts[k+1] - oy + jitter(8),
						pts[k+2] - oz, '0, KIND_NONE, '0, 1'b0));
			end
		end
		if ($urandom_range(0, 4) == 0)
			send(mk(MODE_STOP, jitter(1000), jitter(1000), jitter(1000), {$urandom, $urandom},
				3'($urandom), 23'($urandom), 1'($urandom_range(0, 1))));
	endtask

	initial begin
		#(8 * 2_000_000);
		$display("[waypoint_arrival_tracker_top] ERROR");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle sample, invalid kinds, extremes, full path, stop
		send(mk(MODE_POS, '0, '0, '0, '0, KIND_NONE, '0, 1'b0));
		send(mk(MODE_START, '0, '0, '0, '1, KIND_NONE, '1, 1'b0));
		send(mk(MODE_START, '0, '0, '0, '1, KIND_BAD, '1, 1'b0));
		send(mk(MODE_LOAD, C_MAX, C_MIN, C_MAX, '0, KIND_NONE, '0, 1'b0));
		send(mk(MODE_START, C_MIN, C_MIN, C_MIN, '1, KIND_FACE, '1, 1'b1));
		send(mk(MODE_POS, C_MAX, C_MAX, C_MAX, '0, KIND_NONE, '0, 1'b0));
		send(mk(MODE_POS, C_MAX, C_MAX, C_MAX, '0, KIND_NONE, '0, 1'b0));
		send(mk(MODE_POS, C_MIN, C_MIN, C_MAX, '0, KIND_NONE, '0, 1'b0));
		send(mk(MODE_START, 24'sd1000, '0, '0, 64'd7, KIND_MOVE, '0, 1'b0));
		send(mk(MODE_POS, '0, '0, '0, '0, KIND_NONE, '0, 1'b0));
		send(mk(MODE_POS, 24'sd2000, 24'sd1, 24'sd500, '0, KIND_NONE, '0, 1'b0));
		for (int i = 0; i < 17; i++)
			send(mk(MODE_LOAD, CW'(i * 300), CW'(-i), '0, '0, KIND_NONE, '0, i == 0));
		send(mk(MODE_STOP, '0, '0, '0, '1, KIND_BAD, '1, 1'b1));
		send(mk(MODE_POS, '0, '0, '0, '0, KIND_NONE, '0, 1'b0));

		// configuration phases, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(CFG_ENABLE, ph != 2 && ph != 3);
			write_cfg(CFG_VERT, ph[0]);
			while (sent < 20 + (ph + 1) * 80) begin
				if ($urandom_range(0, 7) == 0)
					send(noise());
				else
					run_route();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[waypoint_arrival_tracker_top] OK");
		else
			$display("[waypoint_arrival_tracker_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
